// File: src/sprm_pkg.sv
// Shared types and constants of the stereo peak and RMS level meter.
package sprm_pkg;

  // Fixed field widths
  localparam int IN_W   = 24;
  localparam int OUT_W  = 23;
  localparam int SUM_W  = 62;

  // Shared divide and square root datapath
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  // Commands from the sequencer to the accumulator
  typedef struct packed {
    logic load;     // capture the magnitudes of a new sample pair
    logic step_l;   // update peaks and count, square the left magnitude
    logic step_r;   // add the left square, square the right magnitude
    logic add_r;    // add the right square
    logic clear;    // start a new metering block
  } acc_ctrl_t;

  // Handshake with the divide and square root unit
  typedef struct packed {
    logic start;
  } ds_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  // Main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_ADD_R,
    ST_START_L,
    ST_WAIT_L,
    ST_START_R,
    ST_WAIT_R,
    ST_EMIT
  } state_t;

  // Divide and square root unit states
  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT
  } ds_state_t;

endpackage

// File: src/stereo_block_peak_rms_meter_unit.sv
// Top level of the stereo block peak and RMS level meter.
// One stereo sample pair is taken per transfer, and no new pair is taken until it is done:
// capture, then the single shared multiplier squares the left and the right magnitude
// in turn and each square is added to its 62-bit sum. The transfer that carries tlast
// is followed by the end-of-block result, which the one shared subtractor forms for each
// channel in turn: 62 restoring divide steps by the sample count and 31 square root
// steps. The next sample is taken only once the result is in the output register. A
// finished result waits in the output register while samples of the next block keep
// flowing. Samples beyond MAX_BLOCK in a block are dropped and flagged. SAMPLE_BITS sets
// how many low bits of each sample are used.
module stereo_block_peak_rms_meter_unit #(
  parameter int MAX_BLOCK   = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sample_left[23:0], sample_right[47:24]
  input  logic        s_tlast,   // block_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata    // peak_left, peak_right, rms_left, rms_right, overflowed
);
  import sprm_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);

  state_t             state;
  state_t             state_next;
  acc_ctrl_t          acc_ctrl;
  ds_ctrl_t           ds_ctrl;
  ds_stat_t           ds_stat;
  logic               room;
  logic [CNT_W-1:0]   count;
  logic               overflow;
  logic [OUT_W-1:0]   peak_left;
  logic [OUT_W-1:0]   peak_right;
  logic [SUM_W-1:0]   sum_left;
  logic [SUM_W-1:0]   sum_right;
  logic [SUM_W-1:0]   ds_dividend;
  logic [OUT_W-1:0]   root;
  logic [OUT_W-1:0]   rms_left_hold;
  logic               last;
  logic               load_out;

  sprm_accum #(
    .MAX_BLOCK   (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CNT_W       (CNT_W)
  ) u_accum (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (acc_ctrl),
    .sample_left  (s_tdata[IN_W-1:0]),
    .sample_right (s_tdata[2*IN_W-1:IN_W]),
    .room         (room),
    .count        (count),
    .overflow     (overflow),
    .peak_left    (peak_left),
    .peak_right   (peak_right),
    .sum_left     (sum_left),
    .sum_right    (sum_right)
  );

  assign ds_dividend = (state == ST_START_R) ? sum_right : sum_left;

  sprm_divsqrt #(
    .CNT_W (CNT_W)
  ) u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ds_ctrl),
    .dividend (ds_dividend),
    .divisor  (count),
    .stat     (ds_stat),
    .root_out (root)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and commands
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    acc_ctrl      = '0;
    ds_ctrl       = '0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          acc_ctrl.load = 1'b1;
          if (room) begin
            state_next = ST_MUL_L;
          end else if (s_tlast) begin
            state_next = ST_START_L;
          end
        end
      end
      ST_MUL_L: begin
        acc_ctrl.step_l = 1'b1;
        state_next      = ST_MUL_R;
      end
      ST_MUL_R: begin
        acc_ctrl.step_r = 1'b1;
        state_next      = ST_ADD_R;
      end
      ST_ADD_R: begin
        acc_ctrl.add_r = 1'b1;
        state_next     = last ? ST_START_L : ST_IDLE;
      end
      ST_START_L: begin
        ds_ctrl.start = 1'b1;
        state_next    = ST_WAIT_L;
      end
      ST_WAIT_L: begin
        if (ds_stat.done) begin
          state_next = ST_START_R;
        end
      end
      ST_START_R: begin
        ds_ctrl.start = 1'b1;
        state_next    = ST_WAIT_R;
      end
      ST_WAIT_R: begin
        if (ds_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out       = 1'b1;
          acc_ctrl.clear = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Block-end flag and the left RMS while the right one is formed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      last <= s_tlast;
    end
    if (state == ST_WAIT_L && ds_stat.done) begin
      rms_left_hold <= root;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {3'b000, overflow, root, rms_left_hold, peak_right, peak_left};
    end
  end

endmodule

// File: src/sprm_accum.sv
// Per-channel magnitude, running peak and sum of squares with one shared multiplier.
module sprm_accum #(
  parameter int MAX_BLOCK   = 65536,
  parameter int SAMPLE_BITS = 24,
  parameter int CNT_W       = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sprm_pkg::acc_ctrl_t          ctrl,
  input  logic [sprm_pkg::IN_W-1:0]    sample_left,
  input  logic [sprm_pkg::IN_W-1:0]    sample_right,
  output logic                         room,
  output logic [CNT_W-1:0]             count,
  output logic                         overflow,
  output logic [sprm_pkg::OUT_W-1:0]   peak_left,
  output logic [sprm_pkg::OUT_W-1:0]   peak_right,
  output logic [sprm_pkg::SUM_W-1:0]   sum_left,
  output logic [sprm_pkg::SUM_W-1:0]   sum_right
);
  import sprm_pkg::*;

  localparam int MAG_W = SAMPLE_BITS - 1;
  localparam int SQ_W  = 2 * MAG_W;

  logic [MAG_W-1:0] mag_left;
  logic [MAG_W-1:0] mag_right;
  logic [MAG_W-1:0] mag_left_next;
  logic [MAG_W-1:0] mag_right_next;
  logic [MAG_W-1:0] run_peak_left;
  logic [MAG_W-1:0] run_peak_right;
  logic [MAG_W-1:0] mul_op;
  logic [SQ_W-1:0]  mul_res;
  logic [SQ_W-1:0]  prod;

  // Magnitude of a two's complement code; the most negative code saturates.
  function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] neg;
    neg = -v;
    if (!v[SAMPLE_BITS-1]) begin
      return v[MAG_W-1:0];
    end else if (neg[SAMPLE_BITS-1]) begin
      return '1;
    end else begin
      return neg[MAG_W-1:0];
    end
  endfunction

  always_comb begin
    mag_left_next  = magnitude(sample_left[SAMPLE_BITS-1:0]);
    mag_right_next = magnitude(sample_right[SAMPLE_BITS-1:0]);
  end

  // The one multiplier squares the left magnitude, then the right one.
  assign mul_op  = ctrl.step_r ? mag_right : mag_left;
  assign mul_res = mul_op * mul_op;

  assign room = (count != CNT_W'(MAX_BLOCK));

  // Captured magnitudes and the registered product
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_left  <= mag_left_next;
      mag_right <= mag_right_next;
    end
    if (ctrl.step_l || ctrl.step_r) begin
      prod <= mul_res;
    end
  end

  // Block state: peaks, sums, count and the dropped-sample flag
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      run_peak_left  <= '0;
      run_peak_right <= '0;
      sum_left       <= '0;
      sum_right      <= '0;
      count          <= '0;
      overflow       <= 1'b0;
    end else begin
      if (ctrl.load && !room) begin
        overflow <= 1'b1;
      end
      if (ctrl.step_l) begin
        if (mag_left > run_peak_left) begin
          run_peak_left <= mag_left;
        end
        if (mag_right > run_peak_right) begin
          run_peak_right <= mag_right;
        end
        count <= count + CNT_W'(1);
      end
      if (ctrl.step_r) begin
        sum_left <= sum_left + SUM_W'(prod);
      end
      if (ctrl.add_r) begin
        sum_right <= sum_right + SUM_W'(prod);
      end
    end
  end

  assign peak_left  = OUT_W'(run_peak_left);
  assign peak_right = OUT_W'(run_peak_right);

endmodule

// File: src/sprm_divsqrt.sv
// Iterative restoring divide followed by a digit-by-digit square root on one subtractor.
module sprm_divsqrt #(
  parameter int CNT_W = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sprm_pkg::ds_ctrl_t           ctrl,
  input  logic [sprm_pkg::SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]             divisor,
  output sprm_pkg::ds_stat_t           stat,
  output logic [sprm_pkg::OUT_W-1:0]   root_out
);
  import sprm_pkg::*;

  ds_state_t         state;
  ds_state_t         state_next;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  work;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [CNT_W-1:0]  div_hold;
  logic              done;
  logic [REM_W-1:0]  op_a;
  logic [REM_W-1:0]  op_b;
  logic [REM_W:0]    diff;
  logic              ge;

  // Shared compare and subtract; operands depend on the phase.
  always_comb begin
    if (state == DS_SQRT) begin
      op_a = {rem[REM_W-3:0], work[SUM_W-1 -: 2]};
      op_b = REM_W'({root, 2'b01});
    end else begin
      op_a = {rem[REM_W-2:0], work[SUM_W-1]};
      op_b = REM_W'(div_hold);
    end
    diff = {1'b0, op_a} - {1'b0, op_b};
    ge   = !diff[REM_W];
  end

  // Phase sequencing
  always_comb begin
    state_next = state;
    case (state)
      DS_IDLE: begin
        if (ctrl.start) begin
          state_next = DS_DIV;
        end
      end
      DS_DIV: begin
        if (step == DIV_LAST) begin
          state_next = DS_SQRT;
        end
      end
      DS_SQRT: begin
        if (step == SQRT_LAST) begin
          state_next = DS_IDLE;
        end
      end
      default: begin
        state_next = DS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DS_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == DS_SQRT) && (step == SQRT_LAST);
    end
  end

  // Datapath: quotient bits shift into work, then root digits come out of it.
  always_ff @(posedge clk) begin
    case (state)
      DS_IDLE: begin
        if (ctrl.start) begin
          work     <= dividend;
          div_hold <= divisor;
          rem      <= '0;
          step     <= '0;
        end
      end
      DS_DIV: begin
        work <= {work[SUM_W-2:0], ge};
        rem  <= ge ? diff[REM_W-1:0] : op_a;
        if (step == DIV_LAST) begin
          step <= '0;
          rem  <= '0;
          root <= '0;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      DS_SQRT: begin
        work <= {work[SUM_W-3:0], 2'b00};
        rem  <= ge ? diff[REM_W-1:0] : op_a;
        root <= {root[ROOT_W-2:0], ge};
        step <= step + STEP_W'(1);
      end
      default: begin
        step <= '0;
      end
    endcase
  end

  assign stat.busy = (state != DS_IDLE);
  assign stat.done = done;
  assign root_out  = root[OUT_W-1:0];

endmodule

// File: src/sprm_checker.sv
// Port-level checks of the level meter, bound to its top level.
module sprm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes the last sample of a block.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("sample taken right after a block end");

  // An RMS value never exceeds the peak of its channel.
  a_rms_left: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[68:46] <= m_tdata[22:0])
    else $error("left rms above left peak");

  a_rms_right: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[91:69] <= m_tdata[45:23])
    else $error("right rms above right peak");

endmodule

bind stereo_block_peak_rms_meter_unit sprm_checker u_sprm_checker (.*);
